FILE: src/hcbt_pkg.sv
// hcbt_pkg: shared types, constants and helper functions of the chunked body tracker
package hcbt_pkg;

  localparam int MAX_HEAD_BYTES_DEF = 32;
  localparam int SIZE_BITS_DEF      = 32;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  typedef enum logic [2:0] {
    PH_HEAD    = 3'd0,
    PH_DATA    = 3'd1,
    PH_TAIL_CR = 3'd2,
    PH_TAIL_LF = 3'd3,
    PH_DONE    = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_TOO_LONG = 3'd1,
    ERR_CRLF     = 3'd2,
    ERR_EXT      = 3'd3,
    ERR_SIZE     = 3'd4
  } err_t;

  typedef enum logic [1:0] {
    ST_NONE = 2'd0,
    ST_400  = 2'd1,
    ST_501  = 2'd2,
    ST_502  = 2'd3
  } status_t;

  typedef struct packed {
    logic    is_payload;
    logic    message_done;
    err_t    error_kind;
    status_t response_status;
  } res_t;

  typedef struct packed {
    logic [7:0] body_byte;
    logic       start_of_body;
  } req_t;

  // bit 4 set when the byte is a hex digit, low nibble is its value
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(b - 8'h30)};
    end else if (b inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(b - 8'h57)};
    end else if (b inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(b - 8'h37)};
    end
    return r;
  endfunction

  function automatic status_t status_of(input err_t kind, input logic client_side);
    status_t s;
    s = ST_NONE;
    if (kind != ERR_NONE) begin
      if (!client_side) begin
        s = ST_502;
      end else if (kind == ERR_TOO_LONG || kind == ERR_EXT) begin
        s = ST_501;
      end else begin
        s = ST_400;
      end
    end
    return s;
  endfunction

endpackage

FILE: src/hcbt_in_stage.sv
// hcbt_in_stage: input register holding one request ahead of the framing logic
module hcbt_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  hcbt_pkg::req_t req,
  input  logic          advance,
  output logic          vld,
  output hcbt_pkg::req_t req_q
);

  logic           vld_r, vld_nxt;
  hcbt_pkg::req_t req_r;
  logic           take;

  assign in_ready = !vld_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (advance) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= req;
    end
  end

  assign vld   = vld_r;
  assign req_q = req_r;

endmodule

FILE: src/hcbt_core.sv
// hcbt_core: framing state and per-byte next-state and result logic
module hcbt_core #(
  parameter int MAX_HEAD_BYTES = hcbt_pkg::MAX_HEAD_BYTES_DEF,
  parameter int SIZE_BITS      = hcbt_pkg::SIZE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  hcbt_pkg::req_t req,
  input  logic           client_side,
  output hcbt_pkg::res_t res
);

  localparam int HC_W = $clog2(MAX_HEAD_BYTES);
  localparam logic [HC_W:0] HC_LIMIT = (HC_W + 1)'(MAX_HEAD_BYTES - 2);

  hcbt_pkg::phase_t     phase_r, phase_nxt, cur_phase;
  hcbt_pkg::err_t       err_r, err_nxt, cur_err;
  logic [HC_W-1:0]      hc_r, hc_nxt, cur_hc;
  logic                 cr_r, cr_nxt, cur_cr;
  logic                 semi_r, semi_nxt, cur_semi;
  logic                 bad_r, bad_nxt, cur_bad;
  logic [SIZE_BITS-1:0] size_r, size_nxt, cur_size;
  logic [SIZE_BITS-1:0] left_r, left_nxt, cur_left;
  logic [SIZE_BITS-1:0] left_dec;
  logic [4:0]           hex;
  logic [7:0]           b;

  assign b   = req.body_byte;
  assign hex = hcbt_pkg::hex_digit(b);

  // start of body clears everything before the byte is looked at
  always_comb begin
    if (req.start_of_body) begin
      cur_phase = hcbt_pkg::PH_HEAD;
      cur_err   = hcbt_pkg::ERR_NONE;
      cur_hc    = '0;
      cur_cr    = 1'b0;
      cur_semi  = 1'b0;
      cur_bad   = 1'b0;
      cur_size  = '0;
      cur_left  = '0;
    end else begin
      cur_phase = phase_r;
      cur_err   = err_r;
      cur_hc    = hc_r;
      cur_cr    = cr_r;
      cur_semi  = semi_r;
      cur_bad   = bad_r;
      cur_size  = size_r;
      cur_left  = left_r;
    end
  end

  assign left_dec = cur_left - SIZE_BITS'(cur_left != '0);

  // next state
  always_comb begin
    phase_nxt = cur_phase;
    err_nxt   = cur_err;
    hc_nxt    = cur_hc;
    cr_nxt    = cur_cr;
    semi_nxt  = cur_semi;
    bad_nxt   = cur_bad;
    size_nxt  = cur_size;
    left_nxt  = cur_left;
    if (cur_err == hcbt_pkg::ERR_NONE) begin
      case (cur_phase)
        hcbt_pkg::PH_HEAD: begin
          if (cur_cr) begin
            if (b != hcbt_pkg::CH_LF) begin
              err_nxt = hcbt_pkg::ERR_CRLF;
            end else if (cur_semi) begin
              err_nxt = hcbt_pkg::ERR_EXT;
            end else if (cur_bad || cur_hc == '0) begin
              err_nxt = hcbt_pkg::ERR_SIZE;
            end else begin
              cr_nxt    = 1'b0;
              hc_nxt    = '0;
              left_nxt  = cur_size;
              phase_nxt = (cur_size == '0) ? hcbt_pkg::PH_TAIL_CR : hcbt_pkg::PH_DATA;
            end
          end else if (b == hcbt_pkg::CH_CR) begin
            cr_nxt = 1'b1;
          end else if ({1'b0, cur_hc} >= HC_LIMIT) begin
            err_nxt = hcbt_pkg::ERR_TOO_LONG;
          end else begin
            hc_nxt = cur_hc + HC_W'(1);
            if (b == hcbt_pkg::CH_SEMI) begin
              semi_nxt = 1'b1;
            end else if (!hex[4] || cur_size[SIZE_BITS-1 -: 4] != 4'd0) begin
              // not a hex digit, or one more digit would overflow
              bad_nxt = 1'b1;
            end else begin
              size_nxt = {cur_size[SIZE_BITS-5:0], hex[3:0]};
            end
          end
        end
        hcbt_pkg::PH_DATA: begin
          left_nxt = left_dec;
          if (left_dec == '0) begin
            phase_nxt = hcbt_pkg::PH_TAIL_CR;
          end
        end
        hcbt_pkg::PH_TAIL_CR: begin
          if (b != hcbt_pkg::CH_CR) begin
            err_nxt = hcbt_pkg::ERR_CRLF;
          end else begin
            phase_nxt = hcbt_pkg::PH_TAIL_LF;
          end
        end
        hcbt_pkg::PH_TAIL_LF: begin
          if (b != hcbt_pkg::CH_LF) begin
            err_nxt = hcbt_pkg::ERR_CRLF;
          end else if (cur_size == '0) begin
            phase_nxt = hcbt_pkg::PH_DONE;
          end else begin
            phase_nxt = hcbt_pkg::PH_HEAD;
            hc_nxt    = '0;
            cr_nxt    = 1'b0;
            semi_nxt  = 1'b0;
            bad_nxt   = 1'b0;
            size_nxt  = '0;
            left_nxt  = '0;
          end
        end
        default: begin
          phase_nxt = cur_phase;
        end
      endcase
    end
  end

  // outputs
  always_comb begin
    res.is_payload   = 1'b0;
    res.message_done = 1'b0;
    if (cur_err == hcbt_pkg::ERR_NONE) begin
      case (cur_phase)
        hcbt_pkg::PH_DATA: begin
          res.is_payload = 1'b1;
        end
        hcbt_pkg::PH_TAIL_LF: begin
          res.message_done = (b == hcbt_pkg::CH_LF) && (cur_size == '0);
        end
        default: begin
          res.is_payload = 1'b0;
        end
      endcase
    end
    res.error_kind      = err_nxt;
    res.response_status = hcbt_pkg::status_of(err_nxt, client_side);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= hcbt_pkg::PH_HEAD;
      err_r   <= hcbt_pkg::ERR_NONE;
      hc_r    <= '0;
      cr_r    <= 1'b0;
      semi_r  <= 1'b0;
      bad_r   <= 1'b0;
      size_r  <= '0;
      left_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
      hc_r    <= hc_nxt;
      cr_r    <= cr_nxt;
      semi_r  <= semi_nxt;
      bad_r   <= bad_nxt;
      size_r  <= size_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

FILE: src/hcbt_out_stage.sv
// hcbt_out_stage: result register towards the output channel
module hcbt_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  hcbt_pkg::res_t res,
  output logic           can_load,
  output logic           out_valid,
  input  logic           out_ready,
  output hcbt_pkg::res_t res_q
);

  logic           vld_r, vld_nxt;
  hcbt_pkg::res_t res_r;

  assign can_load = !vld_r || out_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign res_q     = res_r;

endmodule

FILE: src/http_chunked_body_tracker.sv
// http_chunked_body_tracker: top level of the chunked transfer-coding body tracker
// path: a request is held in the input register, then its result is registered in the result register
// throughput: one body byte per cycle while the result channel keeps out_ready high
// a new request is taken into an empty input register while a finished result still waits in the result register
// reset (rst_n low, synchronous): tracker back to chunk head, no error, both registers empty
// reset also sets client_side to 1 (client request)
module http_chunked_body_tracker #(
  parameter int MAX_HEAD_BYTES = hcbt_pkg::MAX_HEAD_BYTES_DEF,
  parameter int SIZE_BITS      = hcbt_pkg::SIZE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // request channel
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_body_byte,
  input  logic       in_start_of_body,
  // result channel
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_payload,
  output logic       out_message_done,
  output logic [2:0] out_error_kind,
  output logic [1:0] out_response_status,
  // configuration
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  hcbt_pkg::req_t req_in, req_q;
  hcbt_pkg::res_t res, res_q;
  logic           req_vld;
  logic           can_load;
  logic           step;
  logic           client_side_r;

  // client_side selects the status code family; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      client_side_r <= 1'b1;
    end else if (cfg_we) begin
      client_side_r <= cfg_wdata;
    end
  end

  assign req_in.body_byte     = in_body_byte;
  assign req_in.start_of_body = in_start_of_body;

  // a request moves from the input register into the core when the result register frees up
  assign step = req_vld && can_load;

  hcbt_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req      (req_in),
    .advance  (can_load),
    .vld      (req_vld),
    .req_q    (req_q)
  );

  // framing state only changes on the cycle the request is handed on
  hcbt_core #(
    .MAX_HEAD_BYTES (MAX_HEAD_BYTES),
    .SIZE_BITS      (SIZE_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .req         (req_q),
    .client_side (client_side_r),
    .res         (res)
  );

  hcbt_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_q     (res_q)
  );

  assign out_is_payload      = res_q.is_payload;
  assign out_message_done    = res_q.message_done;
  assign out_error_kind      = res_q.error_kind;
  assign out_response_status = res_q.response_status;

endmodule

FILE: tb/tb_framing_pkg.sv
// tb_framing_pkg: scoreboard class that predicts the chunked framing verdict of each body byte
`timescale 1ns / 100ps
package tb_framing_pkg;
  import hcbt_pkg::*;

  localparam int HEAD_LIMIT = MAX_HEAD_BYTES_DEF;
  localparam int SZ_BITS    = SIZE_BITS_DEF;

  class framing_scoreboard;
    bit client_side = 1'b1;

    // framing state of the message being tracked
    phase_t phase = PH_HEAD;
    int unsigned head_len;
    bit cr_seen;
    bit semi_seen;
    bit bad_size;
    logic [SZ_BITS-1:0] chunk_size;
    logic [SZ_BITS-1:0] data_left;
    err_t err = ERR_NONE;

    res_t expected_verdicts[$];

    int unsigned mismatches;
    int unsigned checked;
    int unsigned payload_bytes;
    int unsigned messages_done;
    int unsigned errs_by_kind[8];

    function void clear_framing();
      phase      = PH_HEAD;
      head_len   = 0;
      cr_seen    = 1'b0;
      semi_seen  = 1'b0;
      bad_size   = 1'b0;
      chunk_size = '0;
      data_left  = '0;
      err        = ERR_NONE;
    endfunction

    function status_t status_for(err_t kind);
      if (kind == ERR_NONE) return ST_NONE;
      if (!client_side) return ST_502;
      if (kind == ERR_TOO_LONG || kind == ERR_EXT) return ST_501;
      return ST_400;
    endfunction

    function int hex_nibble(logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
      if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h57);
      if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h37);
      return -1;
    endfunction

    function void head_step(logic [7:0] b);
      int d;
      if (cr_seen) begin
        if (b != CH_LF) begin
          err = ERR_CRLF;
        end else if (semi_seen) begin
          err = ERR_EXT;
        end else if (bad_size || head_len == 0) begin
          err = ERR_SIZE;
        end else begin
          cr_seen   = 1'b0;
          head_len  = 0;
          data_left = chunk_size;
          phase     = (chunk_size == 0) ? PH_TAIL_CR : PH_DATA;
        end
        return;
      end
      if (b == CH_CR) begin
        cr_seen = 1'b1;
        return;
      end
      if (head_len + 3 > HEAD_LIMIT) begin
        err = ERR_TOO_LONG;
        return;
      end
      head_len++;
      if (b == CH_SEMI) begin
        semi_seen = 1'b1;
        return;
      end
      d = hex_nibble(b);
      if (d < 0 || chunk_size[SZ_BITS-1 -: 4] != 0) begin
        bad_size = 1'b1;
      end else begin
        chunk_size = {chunk_size[SZ_BITS-5:0], 4'(d)};
      end
    endfunction

    function void note_request(logic [7:0] b, logic sob);
      res_t v;
      err_t was;
      if (sob) clear_framing();
      was               = err;
      v.is_payload      = 1'b0;
      v.message_done    = 1'b0;
      if (err == ERR_NONE) begin
        case (phase)
          PH_HEAD: head_step(b);
          PH_DATA: begin
            v.is_payload = 1'b1;
            payload_bytes++;
            if (data_left != 0) data_left = data_left - 1'b1;
            if (data_left == 0) phase = PH_TAIL_CR;
          end
          PH_TAIL_CR: begin
            if (b != CH_CR) err = ERR_CRLF;
            else phase = PH_TAIL_LF;
          end
          PH_TAIL_LF: begin
            if (b != CH_LF) begin
              err = ERR_CRLF;
            end else if (chunk_size == 0) begin
              phase          = PH_DONE;
              v.message_done = 1'b1;
              messages_done++;
            end else begin
              clear_framing();
            end
          end
          default: ;
        endcase
      end
      if (was == ERR_NONE && err != ERR_NONE) errs_by_kind[err]++;
      v.error_kind      = err;
      v.response_status = status_for(err);
      expected_verdicts.push_back(v);
    endfunction

    function void compare_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(logic pay, logic done, logic [2:0] kind, logic [1:0] status);
      res_t want;
      if (expected_verdicts.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_verdicts.pop_front();
      checked++;
      compare_field("is_payload", 3'(want.is_payload), 3'(pay));
      compare_field("message_done", 3'(want.message_done), 3'(done));
      compare_field("error_kind", want.error_kind, kind);
      compare_field("response_status", 3'(want.response_status), 3'(status));
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
// tb_top: drives chunked message bodies into the tracker and checks every framing verdict
`timescale 1ns / 100ps
module tb_top;
  import hcbt_pkg::*;
  import tb_framing_pkg::*;

  localparam int RANDOM_ITEMS = 1200;

  // client_side settings
  localparam logic CS_RESPONSE = 1'b0;
  localparam logic CS_REQUEST  = 1'b1;

  // ways a generated message can go wrong
  typedef enum int {
    F_NONE, F_EXT, F_BAD_DIGIT, F_OVERFLOW, F_TOO_LONG, F_LONG_OK,
    F_EMPTY, F_HEAD_CR, F_TAIL, F_TRUNCATE
  } flaw_t;

  logic       clk              = 1'b0;
  logic       rst_n            = 1'b0;
  logic       in_valid         = 1'b0;
  logic       in_ready;
  logic [7:0] in_body_byte     = 8'h00;
  logic       in_start_of_body = 1'b0;
  logic       out_valid;
  logic       out_ready        = 1'b0;
  logic       out_is_payload;
  logic       out_message_done;
  logic [2:0] out_error_kind;
  logic [1:0] out_response_status;
  logic       cfg_we           = 1'b0;
  logic       cfg_wdata        = 1'b0;

  always #5 clk = ~clk;

  http_chunked_body_tracker uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_body_byte        (in_body_byte),
    .in_start_of_body    (in_start_of_body),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_is_payload      (out_is_payload),
    .out_message_done    (out_message_done),
    .out_error_kind      (out_error_kind),
    .out_response_status (out_response_status),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  framing_scoreboard sb = new();

  // bytes still to be sent, each as {start_of_body, body_byte}
  logic [8:0]  byte_plan[$];
  int unsigned live_bytes;
  bit          sob_next;
  int unsigned tx_idle_pct  = 8;
  int unsigned rx_stall_pct = 87;

  // result side: check every accepted result, then decide whether to stall the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_is_payload, out_message_done, out_error_kind, out_response_status);
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------- plan building

  // start_of_body rides on the first byte after sob_next is set
  function automatic void add_byte(logic [7:0] b, bit counted = 1'b1);
    byte_plan.push_back({sob_next, b});
    sob_next = 1'b0;
    if (counted) live_bytes++;
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic void add_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endfunction

  // hex digit with random letter case
  function automatic logic [7:0] hex_char(int unsigned d);
    if (d < 10) return 8'h30 + 8'(d);
    return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(d) - 8'd10;
  endfunction

  function automatic logic [7:0] byte_except(logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == x);
    return b;
  endfunction

  // anything that spoils a size without ending the head or looking like an extension
  function automatic logic [7:0] non_hex_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46], CH_CR, CH_SEMI});
    return b;
  endfunction

  // a few bytes after an error, all of which must repeat the latched error
  function automatic void add_sticky();
    repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(255)));
  endfunction

  // chunk head for size, spoilt as flaw says; returns 1 when the head ends in an error
  function automatic bit emit_head(logic [SZ_BITS-1:0] size, flaw_t flaw);
    int unsigned digits;
    int unsigned pad;
    digits = 1;
    for (int k = 1; k < SZ_BITS / 4; k++)
      if ((size >> (4 * k)) != 0) digits = k + 1;
    pad = $urandom_range(0, 2);
    // the head may hold HEAD_LIMIT-2 content bytes; pad with leading zeros to hit that edge
    if (flaw == F_TOO_LONG) pad = HEAD_LIMIT - 1 - digits + $urandom_range(0, 3);
    if (flaw == F_LONG_OK) pad = HEAD_LIMIT - 2 - digits;
    if (flaw == F_EMPTY) begin
      add_crlf();
      return 1'b1;
    end
    repeat (pad) add_byte(8'h30);
    if (flaw == F_OVERFLOW) begin
      // more significant digits than the size accumulator holds
      add_byte(hex_char($urandom_range(1, 15)));
      repeat (SZ_BITS / 4 + $urandom_range(0, 3)) add_byte(hex_char($urandom_range(15)));
      add_crlf();
      return 1'b1;
    end
    if (flaw == F_BAD_DIGIT && $urandom_range(1)) add_byte(non_hex_byte());
    for (int k = digits; k > 0; k--) add_byte(hex_char(int'((size >> (4 * (k - 1))) & 4'hf)));
    if (flaw == F_BAD_DIGIT) add_byte(non_hex_byte());
    if (flaw == F_EXT) begin
      // extension text may hold non-hex letters too, extension still wins
      add_byte(CH_SEMI);
      repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(8'h61, 8'h7a)));
    end
    if (flaw == F_HEAD_CR) begin
      add_byte(CH_CR);
      add_byte(byte_except(CH_LF));
      return 1'b1;
    end
    add_crlf();
    return flaw inside {F_EXT, F_BAD_DIGIT, F_TOO_LONG};
  endfunction

  // one message body: mostly well formed chunks, sometimes spoilt, sometimes plain noise
  function automatic void build_message();
    int unsigned chunks;
    int unsigned flaw_at;
    flaw_t flaw;
    logic [SZ_BITS-1:0] size;
    sob_next = 1'b1;
    if ($urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(9) == 0) sob_next = 1'b1;
        add_byte(8'($urandom_range(255)));
      end
      return;
    end
    chunks  = $urandom_range(0, 3);
    flaw    = ($urandom_range(99) < 30) ? flaw_t'($urandom_range(F_EXT, F_TRUNCATE)) : F_NONE;
    flaw_at = $urandom_range(0, chunks);
    for (int c = 0; c <= chunks; c++) begin
      if (c == chunks) size = '0;
      else if ($urandom_range(9) == 0) size = SZ_BITS'($urandom_range(9, 64));
      else size = SZ_BITS'($urandom_range(1, 8));
      if (emit_head(size, (c == flaw_at) ? flaw : F_NONE)) begin
        add_sticky();
        return;
      end
      repeat (size) add_byte(8'($urandom_range(255)));
      // cut short: the next message's start_of_body must clear the tracker
      if (c == flaw_at && flaw == F_TRUNCATE) return;
      if (c == flaw_at && flaw == F_TAIL) begin
        if ($urandom_range(1)) begin
          add_byte(byte_except(CH_CR));
        end else begin
          add_byte(CH_CR);
          add_byte(byte_except(CH_LF));
        end
        add_sticky();
        return;
      end
      add_crlf();
    end
    // bytes after the end of the message are ignored by the block
    repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(255)), 1'b0);
  endfunction

  function automatic void build_directed();
    // one data chunk holding 00, then the end of message, then a byte after done
    sob_next = 1'b1;
    add_text("1");
    add_crlf();
    add_byte(8'h00);
    add_crlf();
    add_text("0");
    add_crlf();
    add_crlf();
    add_byte(8'hff);
    // extension, then a byte that must keep the error
    sob_next = 1'b1;
    add_byte(CH_SEMI);
    add_crlf();
    add_text("x");
    // empty head
    sob_next = 1'b1;
    add_crlf();
    // cr inside the head not followed by lf
    sob_next = 1'b1;
    add_byte(CH_CR);
    add_text("A");
    // non-hex digit
    sob_next = 1'b1;
    add_text("G");
    add_crlf();
    // zero chunk whose tail starts with lf instead of cr
    sob_next = 1'b1;
    add_text("0");
    add_crlf();
    add_byte(CH_LF);
  endfunction

  // ---------------------------------------------------------------- driving

  // hand every planned byte over as a request, noting each one at acceptance
  task automatic send_plan();
    logic [8:0] item;
    while (byte_plan.size() != 0) begin
      item = byte_plan.pop_front();
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid                         <= 1'b1;
      {in_start_of_body, in_body_byte} <= item;
      do @(posedge clk); while (!in_ready);
      sb.note_request(item[7:0], item[8]);
    end
    in_valid <= 1'b0;
  endtask

  // wait until every expected verdict has been checked, then let the block idle before going on
  task automatic settle();
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_side(logic side);
    cfg_we    <= 1'b1;
    cfg_wdata <= side;
    @(posedge clk);
    cfg_we         <= 1'b0;
    sb.client_side = side;
  endtask

  task automatic run_random(int unsigned tx_pct, int unsigned rx_pct, logic side,
                            int unsigned count);
    settle();
    write_side(side);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    live_bytes   = 0;
    while (live_bytes < count) build_message();
    send_plan();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed bytes run with client_side at its reset value
    build_directed();
    send_plan();

    // sender rarely idle with a heavily stalled receiver, then the reverse, then flat out
    run_random(8, 87, CS_RESPONSE, RANDOM_ITEMS / 3);
    run_random(87, 8, CS_REQUEST, RANDOM_ITEMS / 3);
    run_random(0, 0, CS_RESPONSE, RANDOM_ITEMS / 6);
    run_random(0, 0, CS_REQUEST, RANDOM_ITEMS / 6);
    settle();

    $display("covered %0d body bytes: %0d chunk data, %0d messages ended, both status sides",
             sb.checked, sb.payload_bytes, sb.messages_done);
    $display("errors raised: head too long %0d, malformed crlf %0d, extension %0d, bad size %0d",
             sb.errs_by_kind[ERR_TOO_LONG], sb.errs_by_kind[ERR_CRLF],
             sb.errs_by_kind[ERR_EXT], sb.errs_by_kind[ERR_SIZE]);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
